// File: src/lacg_pkg.sv
// ---------------------------------------------------------------------------
// lacg_pkg: shared types and codes for the attribute cache
// Request and response beats, controller states, command and status
// groups passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package lacg_pkg;

   localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
   localparam logic [1:0] FUNC_INSTALL = 2'd1;
   localparam logic [1:0] FUNC_INVAL   = 2'd2;
   localparam logic [1:0] FUNC_SNAP    = 2'd3;

   localparam logic [2:0] STS_HIT       = 3'd0;
   localparam logic [2:0] STS_MISS      = 3'd1;
   localparam logic [2:0] STS_INSTALLED = 3'd2;
   localparam logic [2:0] STS_SKIPPED   = 3'd3;
   localparam logic [2:0] STS_INVAL     = 3'd4;
   localparam logic [2:0] STS_ABSENT    = 3'd5;
   localparam logic [2:0] STS_SNAP      = 3'd6;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [63:0] seq_snapshot;
      logic [31:0] version;
      logic [63:0] payload;
   } lacg_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic [63:0] payload_out;
      logic [63:0] gen_out;
      logic        evicted;
   } lacg_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_EVICT,
      ST_DONE
   } lacg_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic evict;
      logic push;
   } lacg_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } lacg_sts_type;

endpackage

// File: src/lru_attr_cache_gen_guard_top.sv
// ---------------------------------------------------------------------------
// lru_attr_cache_gen_guard_top: fully associative LRU attribute cache
// A request beat passes through the execute and done states into the response
//   register; an evicting install adds a stamp scan through one read port.
// Requests are taken in idle, or in done while the response register is free.
// Reset clears valid bits, use clock and generation.
// ---------------------------------------------------------------------------
module lru_attr_cache_gen_guard_top #(
   parameter int ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lacg_pkg::lacg_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lacg_pkg::lacg_rsp_type rsp_item
);

   lacg_pkg::lacg_cmd_type cmd;
   lacg_pkg::lacg_sts_type sts;

   lacg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lacg_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

`ifndef SYNTHESIS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.exec)
      else $error("request beat not followed by execute");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.scan, cmd.evict, cmd.push}))
      else $error("more than one datapath command");

   a_evict_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> ($past(cmd.scan) && $past(sts.scan_last)))
      else $error("eviction without completed victim scan");
`endif

endmodule

// File: src/lacg_ctrl.sv
// ---------------------------------------------------------------------------
// lacg_ctrl: operation sequencer for the attribute cache
// Steps each request through execute, optional victim scan and eviction,
// and hands the result to the response register.
// ---------------------------------------------------------------------------
module lacg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lacg_pkg::lacg_sts_type sts,
   output lacg_pkg::lacg_cmd_type cmd
);

   lacg_pkg::lacg_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lacg_pkg::ST_IDLE: begin
            if (accept) state_in = lacg_pkg::ST_EXEC;
         end
         lacg_pkg::ST_EXEC: begin
            state_in = sts.need_scan ? lacg_pkg::ST_SCAN : lacg_pkg::ST_DONE;
         end
         lacg_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = lacg_pkg::ST_EVICT;
         end
         lacg_pkg::ST_EVICT: begin
            state_in = lacg_pkg::ST_DONE;
         end
         lacg_pkg::ST_DONE: begin
            if (out_free) state_in = accept ? lacg_pkg::ST_EXEC : lacg_pkg::ST_IDLE;
         end
         default: begin
            state_in = lacg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = !((state_ff == lacg_pkg::ST_IDLE) ||
                    ((state_ff == lacg_pkg::ST_DONE) && out_free));
      cmd.load  = req_valid && !req_stall;
      cmd.exec  = (state_ff == lacg_pkg::ST_EXEC);
      cmd.scan  = (state_ff == lacg_pkg::ST_SCAN);
      cmd.evict = (state_ff == lacg_pkg::ST_EVICT);
      cmd.push  = (state_ff == lacg_pkg::ST_DONE) && out_free;
   end

   always_comb begin
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lacg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/lacg_dpath.sv
// ---------------------------------------------------------------------------
// lacg_dpath: slot storage and result datapath of the attribute cache
// Keys and valid bits in flops for the parallel compare, stamps and
// payload words in memories, LRU victim scan, response register.
// ---------------------------------------------------------------------------
module lacg_dpath #(
   parameter int ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lacg_pkg::lacg_req_type req_item,
   input  lacg_pkg::lacg_cmd_type cmd,
   output lacg_pkg::lacg_sts_type sts,
   output lacg_pkg::lacg_rsp_type rsp_item
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef struct packed {
      logic [31:0] version;
      logic [63:0] payload;
   } slot_data_type;

   lacg_pkg::lacg_req_type req_ff;
   lacg_pkg::lacg_rsp_type rsp_ff;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0]        key_ff [ENTRIES];
   logic [63:0]        stamp_mem [ENTRIES];
   slot_data_type      slot_mem [ENTRIES];

   logic [63:0]   uc_ff, uc_in;
   logic [63:0]   gen_ff, gen_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic          res_hit_ff, res_hit_in;
   logic [63:0]   res_gen_ff, res_gen_in;
   logic          res_ev_ff, res_ev_in;
   slot_data_type slot_rd_ff;
   logic [63:0]   stamp_rd_ff;
   logic [CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic [63:0]   best_stamp_ff;
   logic [IW-1:0] best_idx_ff;

   logic          hit;
   logic [IW-1:0] hit_idx;
   logic          free_any;
   logic [IW-1:0] free_idx;
   logic          gen_match;
   logic          inst_we;
   logic [IW-1:0] inst_idx;
   logic          st_we;
   logic [IW-1:0] st_idx;

   // first matching slot and first free slot, lowest index wins
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!hit && valid_ff[i] && (key_ff[i] == req_ff.key)) begin
            hit     = 1'b1;
            hit_idx = IW'(i);
         end
         if (!free_any && !valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign gen_match     = (gen_ff == req_ff.seq_snapshot);
   assign sts.need_scan = (req_ff.func == lacg_pkg::FUNC_INSTALL) && gen_match &&
                          !hit && !free_any;
   assign sts.scan_last = (scan_cnt_ff == CW'(ENTRIES));

   always_comb begin
      valid_in      = valid_ff;
      gen_in        = gen_ff;
      uc_in         = uc_ff;
      res_status_in = res_status_ff;
      res_hit_in    = res_hit_ff;
      res_gen_in    = res_gen_ff;
      res_ev_in     = res_ev_ff;
      inst_we       = 1'b0;
      inst_idx      = hit_idx;
      st_we         = 1'b0;
      st_idx        = hit_idx;
      if (cmd.exec) begin
         res_hit_in = 1'b0;
         res_gen_in = '0;
         res_ev_in  = 1'b0;
         case (req_ff.func)
            lacg_pkg::FUNC_LOOKUP: begin
               if (hit) begin
                  res_status_in = lacg_pkg::STS_HIT;
                  res_hit_in    = 1'b1;
                  st_we         = 1'b1;
               end else begin
                  res_status_in = lacg_pkg::STS_MISS;
                  res_gen_in    = gen_ff;
               end
            end
            lacg_pkg::FUNC_INSTALL: begin
               if (!gen_match) begin
                  res_status_in = lacg_pkg::STS_SKIPPED;
               end else if (hit || free_any) begin
                  inst_we       = 1'b1;
                  inst_idx      = hit ? hit_idx : free_idx;
                  res_status_in = lacg_pkg::STS_INSTALLED;
               end
            end
            lacg_pkg::FUNC_INVAL: begin
               gen_in = gen_ff + 64'd1;
               if (hit) begin
                  valid_in[hit_idx] = 1'b0;
                  res_status_in     = lacg_pkg::STS_INVAL;
               end else begin
                  res_status_in = lacg_pkg::STS_ABSENT;
               end
            end
            default: begin
               res_status_in = lacg_pkg::STS_SNAP;
               res_gen_in    = gen_ff;
            end
         endcase
      end
      if (cmd.evict) begin
         inst_we       = 1'b1;
         inst_idx      = best_idx_ff;
         res_status_in = lacg_pkg::STS_INSTALLED;
         res_hit_in    = 1'b0;
         res_gen_in    = '0;
         res_ev_in     = 1'b1;
      end
      if (inst_we) begin
         st_we              = 1'b1;
         st_idx             = inst_idx;
         valid_in[inst_idx] = 1'b1;
      end
      if (st_we) begin
         uc_in = uc_ff + 64'd1;
      end
   end

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (cmd.exec) begin
         scan_cnt_in = '0;
      end else if (cmd.scan) begin
         scan_cnt_in = scan_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         uc_ff       <= '0;
         gen_ff      <= '0;
         scan_cnt_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         uc_ff       <= uc_in;
         gen_ff      <= gen_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_item;
      res_status_ff <= res_status_in;
      res_hit_ff    <= res_hit_in;
      res_gen_ff    <= res_gen_in;
      res_ev_ff     <= res_ev_in;
      if (inst_we) key_ff[inst_idx] <= req_ff.key;
      // compare the stamp read last cycle; strict less keeps the lowest index on ties
      if (cmd.scan && (scan_cnt_ff != '0)) begin
         if ((scan_cnt_ff == CW'(1)) || (stamp_rd_ff < best_stamp_ff)) begin
            best_stamp_ff <= stamp_rd_ff;
            best_idx_ff   <= IW'(scan_cnt_ff - CW'(1));
         end
      end
      if (cmd.push) begin
         rsp_ff.status      <= res_status_ff;
         rsp_ff.hit         <= res_hit_ff;
         rsp_ff.payload_out <= res_hit_ff ? slot_rd_ff.payload : 64'd0;
         rsp_ff.gen_out     <= res_gen_ff;
         rsp_ff.evicted     <= res_ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) stamp_mem[st_idx] <= uc_in;
      stamp_rd_ff <= stamp_mem[scan_cnt_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (inst_we) slot_mem[inst_idx] <= '{version: req_ff.version, payload: req_ff.payload};
      if (cmd.exec) slot_rd_ff <= slot_mem[hit_idx];
   end

   assign rsp_item = rsp_ff;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the LRU attribute cache with generation guard
// Walks a short directed table with typed-in responses for the plain cases.
// Then it runs random lookup/install/invalidate/snapshot traffic over a small
// key pool, so the 16 lines fill and get evicted. Every untyped response beat is
// compared field by field against a cycle-free model of the cache that is
// updated at each accepted request. The bench idles and stalls both channels
// at random, holds the response side off long enough to back up the block,
// and drains it with the request side paused.
// ---------------------------------------------------------------------------
module tb;

   localparam int ENTRIES     = 16;
   localparam int KEY_POOL    = 24;
   localparam int HOLD_CYCLES = 150;
   localparam logic [63:0] ALL1 = '1;
   localparam logic [63:0] Z64  = '0;

   typedef enum {RX_RANDOM, RX_STEADY, RX_HOLD} rx_mode_type;

   typedef struct {
      lacg_pkg::lacg_req_type rq;
      bit                     typed;
      lacg_pkg::lacg_rsp_type rsp;
   } dir_row_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   lacg_pkg::lacg_req_type req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   lacg_pkg::lacg_rsp_type rsp_item;

   rx_mode_type  rx_mode = RX_RANDOM;
   int           hold_cnt = 0;
   bit           tx_idle_on = 1'b1;

   lacg_pkg::lacg_rsp_type awaited_rsps [$];
   dir_row_type            stim_tbl [$];
   logic [63:0]            key_pool [KEY_POOL];

   int err_count   = 0;
   int req_count   = 0;
   int rsp_count   = 0;
   int hit_count   = 0;
   int evict_count = 0;
   int skip_count  = 0;

   // cache model state
   bit        line_valid   [ENTRIES];
   bit [63:0] line_key     [ENTRIES];
   bit [31:0] line_version [ENTRIES];
   bit [63:0] line_payload [ENTRIES];
   bit [63:0] line_stamp   [ENTRIES];
   bit [63:0] stamp_tick = '0;
   bit [63:0] cache_gen = '0;

   lru_attr_cache_gen_guard_top #(
      .ENTRIES(ENTRIES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout with %0d responses outstanding", $time, awaited_rsps.size());
      $display("tb: failure");
      $finish;
   end

   function automatic int match_line(input logic [63:0] key);
      int found;
      int i;
      found = -1;
      for (i = ENTRIES - 1; i >= 0; i--) begin
         if (line_valid[i] && line_key[i] == key) found = i;
      end
      return found;
   endfunction

   function automatic lacg_pkg::lacg_rsp_type predict_cache_rsp(
         input lacg_pkg::lacg_req_type rq);
      lacg_pkg::lacg_rsp_type r;
      int s;
      int free_idx;
      int victim;
      int i;
      r = '0;
      case (rq.func)
         lacg_pkg::FUNC_LOOKUP: begin
            s = match_line(rq.key);
            if (s >= 0) begin
               stamp_tick    = stamp_tick + 1;
               line_stamp[s] = stamp_tick;
               r.status      = lacg_pkg::STS_HIT;
               r.hit         = 1'b1;
               r.payload_out = line_payload[s];
            end else begin
               r.status  = lacg_pkg::STS_MISS;
               r.gen_out = cache_gen;
            end
         end
         lacg_pkg::FUNC_INSTALL: begin
            if (rq.seq_snapshot != cache_gen) begin
               r.status = lacg_pkg::STS_SKIPPED;
            end else begin
               s        = match_line(rq.key);
               free_idx = -1;
               victim   = -1;
               // lowest free line; oldest stamp wins, lowest index on a tie
               for (i = 0; i < ENTRIES; i++) begin
                  if (!line_valid[i]) begin
                     if (free_idx < 0) free_idx = i;
                  end else if (victim < 0 || line_stamp[i] < line_stamp[victim]) begin
                     victim = i;
                  end
               end
               if (s < 0) begin
                  if (free_idx >= 0) begin
                     s = free_idx;
                  end else begin
                     s         = victim;
                     r.evicted = 1'b1;
                  end
               end
               stamp_tick      = stamp_tick + 1;
               line_valid[s]   = 1'b1;
               line_key[s]     = rq.key;
               line_version[s] = rq.version;
               line_payload[s] = rq.payload;
               line_stamp[s]   = stamp_tick;
               r.status        = lacg_pkg::STS_INSTALLED;
            end
         end
         lacg_pkg::FUNC_INVAL: begin
            cache_gen = cache_gen + 1;
            s = match_line(rq.key);
            if (s >= 0) begin
               line_valid[s] = 1'b0;
               r.status      = lacg_pkg::STS_INVAL;
            end else begin
               r.status = lacg_pkg::STS_ABSENT;
            end
         end
         default: begin
            r.status  = lacg_pkg::STS_SNAP;
            r.gen_out = cache_gen;
         end
      endcase
      return r;
   endfunction

   function automatic dir_row_type drow(input logic [1:0] f, input logic [63:0] k,
                                        input logic [63:0] sn, input logic [31:0] v,
                                        input logic [63:0] p, input bit typed,
                                        input logic [2:0] st, input logic [63:0] po,
                                        input logic [63:0] go, input bit ev);
      dir_row_type row;
      row.rq.func             = f;
      row.rq.key              = k;
      row.rq.seq_snapshot     = sn;
      row.rq.version          = v;
      row.rq.payload          = p;
      row.typed               = typed;
      row.rsp.status          = st;
      row.rsp.hit             = (st == lacg_pkg::STS_HIT);
      row.rsp.payload_out     = po;
      row.rsp.gen_out         = go;
      row.rsp.evicted         = ev;
      return row;
   endfunction

   function automatic lacg_pkg::lacg_req_type rand_req();
      lacg_pkg::lacg_req_type rq;
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)      rq.func = lacg_pkg::FUNC_LOOKUP;
      else if (pick < 70) rq.func = lacg_pkg::FUNC_INSTALL;
      else if (pick < 85) rq.func = lacg_pkg::FUNC_INVAL;
      else                rq.func = lacg_pkg::FUNC_SNAP;
      if ($urandom_range(99) < 90) rq.key = key_pool[$urandom_range(KEY_POOL - 1)];
      else                         rq.key = {$urandom, $urandom};
      // mostly a current snapshot so installs land; the rest stale or junk
      pick = $urandom_range(99);
      if (pick < 80)      rq.seq_snapshot = cache_gen;
      else if (pick < 90) rq.seq_snapshot = cache_gen - 1;
      else                rq.seq_snapshot = {$urandom, $urandom};
      rq.version = $urandom;
      rq.payload = {$urandom, $urandom};
      return rq;
   endfunction

   task automatic issue_req(input lacg_pkg::lacg_req_type rq, input bit typed,
                            input lacg_pkg::lacg_rsp_type fixed);
      lacg_pkg::lacg_rsp_type predicted;
      req_valid <= 1'b1;
      req_item  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_cache_rsp(rq);
      awaited_rsps.push_back(typed ? fixed : predicted);
      req_count++;
      if (tx_idle_on && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++) issue_req(rand_req(), 1'b0, '0);
   endtask

   task automatic cmp_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         err_count++;
      end
   endtask

   task automatic check_rsp(input lacg_pkg::lacg_rsp_type got);
      lacg_pkg::lacg_rsp_type want;
      if (awaited_rsps.size() == 0) begin
         $display("%0t: response beat with nothing expected: expected none, actual %p",
                  $time, got);
         err_count++;
      end else begin
         want = awaited_rsps.pop_front();
         cmp_field("status",      64'(want.status),  64'(got.status));
         cmp_field("hit",         64'(want.hit),     64'(got.hit));
         cmp_field("payload_out", want.payload_out,  got.payload_out);
         cmp_field("gen_out",     want.gen_out,      got.gen_out);
         cmp_field("evicted",     64'(want.evicted), 64'(got.evicted));
      end
      rsp_count++;
      if (got.hit === 1'b1) hit_count++;
      if (got.evicted === 1'b1) evict_count++;
      if (got.status === lacg_pkg::STS_SKIPPED) skip_count++;
   endtask

   // response side: check each beat, then pick the stall for the next edge
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) check_rsp(rsp_item);
      case (rx_mode)
         RX_HOLD: begin
            if (hold_cnt < HOLD_CYCLES) begin
               hold_cnt  <= hold_cnt + 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
         RX_STEADY: begin
            hold_cnt  <= 0;
            rsp_stall <= 1'b0;
         end
         default: begin
            hold_cnt  <= 0;
            rsp_stall <= ($urandom_range(99) < 27);
         end
      endcase
   end

   initial begin
      int i;
      key_pool[0] = Z64;
      key_pool[1] = ALL1;
      for (i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

      // directed table: typed rows carry the response, the rest go to the model
      stim_tbl.push_back(drow(lacg_pkg::FUNC_SNAP, Z64, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_SNAP, Z64, 64'd0, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, ALL1, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_MISS, Z64, 64'd0, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, Z64, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_MISS, Z64, 64'd0, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INSTALL, ALL1, 64'd0, 32'hFFFF_FFFF, ALL1,
                              1, lacg_pkg::STS_INSTALLED, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INSTALL, Z64, 64'd0, 32'h0, Z64,
                              1, lacg_pkg::STS_INSTALLED, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, ALL1, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_HIT, ALL1, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, Z64, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_HIT, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INSTALL, 64'hA5A5_A5A5_A5A5_A5A5, ALL1,
                              32'h1, ALL1,
                              1, lacg_pkg::STS_SKIPPED, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INSTALL, ALL1, 64'd0,
                              32'h1234, 64'h0123_4567_89AB_CDEF,
                              1, lacg_pkg::STS_INSTALLED, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, ALL1, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_HIT, 64'h0123_4567_89AB_CDEF, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INVAL, Z64, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_INVAL, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INVAL, Z64, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_ABSENT, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, Z64, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_MISS, Z64, 64'd2, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INSTALL, Z64, 64'd1, 32'h0, ALL1,
                              1, lacg_pkg::STS_SKIPPED, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INSTALL, Z64, 64'd2,
                              32'h8000_0000, 64'h8000_0000_0000_0000,
                              1, lacg_pkg::STS_INSTALLED, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_SNAP, ALL1, ALL1, 32'hFFFF_FFFF, ALL1,
                              1, lacg_pkg::STS_SNAP, Z64, 64'd2, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, Z64, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_HIT, 64'h8000_0000_0000_0000, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INVAL, ALL1, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_INVAL, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, ALL1, Z64, 32'h0, Z64,
                              1, lacg_pkg::STS_MISS, Z64, 64'd3, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_INSTALL, 64'd1, 64'd3,
                              32'h5A5A_5A5A, 64'h5555_AAAA_5555_AAAA,
                              0, lacg_pkg::STS_HIT, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_LOOKUP, 64'd1, Z64, 32'h0, Z64,
                              0, lacg_pkg::STS_HIT, Z64, Z64, 0));
      stim_tbl.push_back(drow(lacg_pkg::FUNC_SNAP, Z64, Z64, 32'h0, Z64,
                              0, lacg_pkg::STS_HIT, Z64, Z64, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_tbl[n]) issue_req(stim_tbl[n].rq, stim_tbl[n].typed, stim_tbl[n].rsp);

      run_random(180);

      // steady stretch: no idling on either side
      rx_mode    <= RX_STEADY;
      tx_idle_on  = 1'b0;
      run_random(100);

      // back the block up, then pause requests until it drains
      rx_mode <= RX_HOLD;
      run_random(40);
      req_valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      rx_mode    <= RX_RANDOM;
      tx_idle_on  = 1'b1;

      run_random(180);
      req_valid <= 1'b0;

      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);

      $display("tb: %0d requests and %0d responses (%0d hits, %0d evictions, %0d skipped)",
               req_count, rsp_count, hit_count, evict_count, skip_count);
      $display("tb: generation reached %0d, use counter reached %0d", cache_gen, stamp_tick);
      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
src/lacg_pkg.sv
src/lacg_ctrl.sv
src/lacg_dpath.sv
src/lru_attr_cache_gen_guard_top.sv
verif/tb.sv
